// ===== hw/rtl/pais_pkg.sv =====
// ============================================================================
// pais_pkg: shared types and constants for the packed array core
// Holds the operation and status codes, the sequencer state type and the
// fixed port widths used by the packed array insert/search/delete core.
// ============================================================================
`default_nettype none

package pais_pkg;

    // Fixed field widths of the command and result words.
    localparam int FUNC_W = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 4;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 4;
    localparam int STAT_W = 3;

    // Default number of array entries.
    localparam int DEFAULT_CAPACITY = 8;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    // Index reported when nothing was written, found or removed.
    localparam logic [IDX_W-1:0] NO_INDEX = 4'hF;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/pais_mem.sv =====
// ============================================================================
// pais_mem: entry storage
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ============================================================================
`default_nettype none

module pais_mem #(
    parameter int DEPTH = pais_pkg::DEFAULT_CAPACITY,
    parameter int WIDTH = pais_pkg::KEY_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/packed_array_insert_search_delete_core.sv =====
// A word taken on start gives one result strobe when it finishes; rejected or
//   non-shifting words finish from the idle state, while shifts and scans take an issue
//   step and then one step per entry touched (plus one step for the final insert write).
// One word at a time: scans and shifts hold busy until the strobe cycle, which takes start again.
// The single RAM port pair (one read, one write per cycle) sets the per-entry cost.
// Reset is synchronous: count and control clear, array contents are kept and are not cleared.
// ============================================================================
// packed_array_insert_search_delete_core: packed array with insert/search/delete
// A sequencer walks the entry RAM one entry per cycle to scan for a key or to
// shift entries up (insert) or down (delete) and reports one result per word.
// ============================================================================
`default_nettype none

module packed_array_insert_search_delete_core #(
    parameter int CAPACITY = pais_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [pais_pkg::FUNC_W-1:0]  i_func,
    input  wire logic signed [pais_pkg::KEY_W-1:0]   i_key,
    input  wire logic        [pais_pkg::POS_W-1:0]   i_pos,
    output logic                                     o_valid,
    output logic signed      [pais_pkg::IDX_W-1:0]   o_found_index,
    output logic             [pais_pkg::CNT_W-1:0]   o_new_count,
    output logic             [pais_pkg::STAT_W-1:0]  o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Converts an entry address to the reported index width.
    function automatic logic [pais_pkg::IDX_W-1:0] idx_out(input logic [AW-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[pais_pkg::IDX_W-1:0];
    endfunction

    pais_pkg::t_state r_state, n_state;

    logic [pais_pkg::FUNC_W-1:0] r_func, n_func;
    logic [pais_pkg::KEY_W-1:0]  r_key, n_key;
    logic [AW-1:0]               r_slot, n_slot;
    logic [AW-1:0]               r_pend_addr, n_pend_addr;
    logic [AW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_valid, n_valid;
    logic [pais_pkg::IDX_W-1:0]  r_found, n_found;
    logic [pais_pkg::STAT_W-1:0] r_status, n_status;

    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [pais_pkg::KEY_W-1:0]  mem_wdata, mem_rdata;

    logic        accept;
    logic [31:0] pos32, cnt32, pos_m1, cnt_m1;
    logic [AW-1:0] slot_in, top_addr;
    logic        is_full, is_empty, bad_pos, at_end;
    logic        hit, last;

    // Entry storage.
    pais_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (pais_pkg::KEY_W),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decode of the incoming word and the scan conditions.
    always_comb begin
        accept   = start && !busy;
        pos32    = 32'(i_pos);
        cnt32    = 32'(r_count);
        pos_m1   = pos32 - 32'd1;
        cnt_m1   = cnt32 - 32'd1;
        slot_in  = pos_m1[AW-1:0];
        top_addr = cnt_m1[AW-1:0];
        is_full  = (r_count == CAP_C);
        is_empty = (r_count == '0);
        bad_pos  = (pos32 == 32'd0) || (pos32 > cnt32 + 32'd1);
        at_end   = (pos32 == cnt32 + 32'd1);
        hit      = (mem_rdata == r_key);
        last     = (32'(r_pend_addr) == cnt_m1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pais_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_func == pais_pkg::FUNC_INSERT) begin
                        if (!is_full && !bad_pos && !at_end) begin
                            n_state = pais_pkg::S_SHIFT_UP;
                        end
                    end else if (i_func == pais_pkg::FUNC_SEARCH ||
                                 i_func == pais_pkg::FUNC_DELETE) begin
                        if (!is_empty) begin
                            n_state = pais_pkg::S_SCAN;
                        end
                    end
                end
            end
            pais_pkg::S_SCAN: begin
                if (hit) begin
                    if (r_func == pais_pkg::FUNC_DELETE && !last) begin
                        n_state = pais_pkg::S_SHIFT_DN;
                    end else begin
                        n_state = pais_pkg::S_IDLE;
                    end
                end else if (last) begin
                    n_state = pais_pkg::S_IDLE;
                end
            end
            pais_pkg::S_SHIFT_UP: begin
                if (r_pend_addr == r_slot) begin
                    n_state = pais_pkg::S_PUT;
                end
            end
            pais_pkg::S_PUT: begin
                n_state = pais_pkg::S_IDLE;
            end
            pais_pkg::S_SHIFT_DN: begin
                if (last) begin
                    n_state = pais_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pais_pkg::S_IDLE;
            end
        endcase
    end

    // Memory accesses and result values. The write and the read in one cycle
    // always hit different entries (two apart while shifting), and the last
    // write of a word lands before the next word can issue a read.
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_pend_addr;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = r_pend_addr;
        n_func      = r_func;
        n_key       = r_key;
        n_slot      = r_slot;
        n_pend_addr = r_pend_addr;
        n_idx       = r_idx;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_status    = r_status;
        unique case (r_state)
            pais_pkg::S_IDLE: begin
                if (accept) begin
                    n_func   = i_func;
                    n_key    = i_key;
                    n_slot   = slot_in;
                    n_found  = pais_pkg::NO_INDEX;
                    n_status = pais_pkg::STAT_OK;
                    if (i_func == pais_pkg::FUNC_INSERT) begin
                        if (is_full) begin
                            n_valid  = 1'b1;
                            n_status = pais_pkg::STAT_FULL;
                        end else if (bad_pos) begin
                            n_valid  = 1'b1;
                            n_status = pais_pkg::STAT_BADPOS;
                        end else if (at_end) begin
                            // Append: nothing to shift.
                            mem_we    = 1'b1;
                            mem_waddr = slot_in;
                            mem_wdata = i_key;
                            n_count   = r_count + CW'(1);
                            n_found   = idx_out(slot_in);
                            n_valid   = 1'b1;
                        end else begin
                            mem_re      = 1'b1;
                            mem_raddr   = top_addr;
                            n_pend_addr = top_addr;
                        end
                    end else if (i_func == pais_pkg::FUNC_SEARCH ||
                                 i_func == pais_pkg::FUNC_DELETE) begin
                        if (is_empty) begin
                            n_valid  = 1'b1;
                            n_status = (i_func == pais_pkg::FUNC_DELETE) ?
                                       pais_pkg::STAT_EMPTY : pais_pkg::STAT_NOTFOUND;
                        end else begin
                            mem_re      = 1'b1;
                            mem_raddr   = '0;
                            n_pend_addr = '0;
                        end
                    end else begin
                        // Unused code: report without touching the array.
                        n_valid = 1'b1;
                    end
                end
            end
            pais_pkg::S_SCAN: begin
                if (hit) begin
                    n_idx = r_pend_addr;
                    if (r_func == pais_pkg::FUNC_DELETE && !last) begin
                        mem_re      = 1'b1;
                        mem_raddr   = r_pend_addr + AW'(1);
                        n_pend_addr = r_pend_addr + AW'(1);
                    end else begin
                        n_valid = 1'b1;
                        n_found = idx_out(r_pend_addr);
                        if (r_func == pais_pkg::FUNC_DELETE) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end else if (last) begin
                    n_valid  = 1'b1;
                    n_status = pais_pkg::STAT_NOTFOUND;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_pend_addr + AW'(1);
                    n_pend_addr = r_pend_addr + AW'(1);
                end
            end
            pais_pkg::S_SHIFT_UP: begin
                // Move the entry just read one place up.
                mem_we    = 1'b1;
                mem_waddr = r_pend_addr + AW'(1);
                if (r_pend_addr != r_slot) begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_pend_addr - AW'(1);
                    n_pend_addr = r_pend_addr - AW'(1);
                end
            end
            pais_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_slot;
                mem_wdata = r_key;
                n_count   = r_count + CW'(1);
                n_found   = idx_out(r_slot);
                n_valid   = 1'b1;
            end
            pais_pkg::S_SHIFT_DN: begin
                // Move the entry just read one place down.
                mem_we    = 1'b1;
                mem_waddr = r_pend_addr - AW'(1);
                if (last) begin
                    n_count = r_count - CW'(1);
                    n_found = idx_out(r_idx);
                    n_valid = 1'b1;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_pend_addr + AW'(1);
                    n_pend_addr = r_pend_addr + AW'(1);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pais_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_key       <= n_key;
        r_slot      <= n_slot;
        r_pend_addr <= n_pend_addr;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_status    <= n_status;
    end

    // Output drive.
    always_comb begin
        busy          = (r_state != pais_pkg::S_IDLE);
        o_valid       = r_valid;
        o_found_index = r_found;
        o_new_count   = cnt32[pais_pkg::CNT_W-1:0];
        o_status      = r_status;
    end

`ifndef ASSERT_OFF
    // A result is only shown once the sequencer is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Every accepted word either finishes at once or keeps the core busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted word neither finished nor in progress");

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // The count only changes together with a reported result.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> o_valid)
        else $error("entry count changed without a result");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_packed_array_insert_search_delete_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_packed_array_insert_search_delete_core: self-checking bench for the core
// Sends insert, search, delete and no-op command words, and keeps its own copy of the
// packed array to predict each result word. Every strobed result is checked
// field by field against the oldest prediction. A directed pass covers the
// corner cases. Fill and drain sequences and random traffic follow, with random
// sender gaps, a full drain pause, and a back-to-back stretch at the end.
// ============================================================================

module tb_packed_array_insert_search_delete_core;

    import pais_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;

    // The core treats the spare operation code as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    // Expected contents of one result word.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [STAT_W-1:0] stat;
    } t_array_result;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start   = 1'b0;
    logic                       busy;
    logic        [FUNC_W-1:0]   i_func  = '0;
    logic signed [KEY_W-1:0]    i_key   = '0;
    logic        [POS_W-1:0]    i_pos   = '0;
    logic                       o_valid;
    logic signed [IDX_W-1:0]    o_found_index;
    logic        [CNT_W-1:0]    o_new_count;
    logic        [STAT_W-1:0]   o_status;

    // Shadow copy of the array and the queue of predicted result words.
    logic [KEY_W-1:0] arr_vals [CAPACITY];
    int               arr_count;
    t_array_result    pending_results [$];
    t_array_result    head_result;
    int               errors;
    bit               no_gaps;
    int               gap_pct;

    packed_array_insert_search_delete_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_pos         (i_pos),
        .o_valid       (o_valid),
        .o_found_index (o_found_index),
        .o_new_count   (o_new_count),
        .o_status      (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Index of the first live entry equal to the key, or -1.
    function automatic int locate_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < arr_count; i++) begin
            if (arr_vals[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command word to the shadow array and returns its result word.
    function automatic t_array_result apply_array_op(logic [FUNC_W-1:0] f,
                                                     logic [KEY_W-1:0] k,
                                                     logic [POS_W-1:0] p);
        t_array_result r;
        int            slot;
        int            at;
        r.idx  = NO_INDEX;
        r.stat = STAT_OK;
        slot   = int'(p) - 1;
        case (f)
            FUNC_INSERT: begin
                if (arr_count >= CAPACITY) begin
                    r.stat = STAT_FULL;
                end else if (slot < 0 || slot > arr_count) begin
                    r.stat = STAT_BADPOS;
                end else begin
                    for (int i = arr_count; i > slot; i--) begin
                        arr_vals[i] = arr_vals[i-1];
                    end
                    arr_vals[slot] = k;
                    arr_count++;
                    r.idx = IDX_W'(slot);
                end
            end
            FUNC_SEARCH: begin
                at = locate_key(k);
                if (at >= 0) begin
                    r.idx = IDX_W'(at);
                end else begin
                    r.stat = STAT_NOTFOUND;
                end
            end
            FUNC_DELETE: begin
                if (arr_count == 0) begin
                    r.stat = STAT_EMPTY;
                end else begin
                    at = locate_key(k);
                    if (at < 0) begin
                        r.stat = STAT_NOTFOUND;
                    end else begin
                        for (int i = at; i + 1 < arr_count; i++) begin
                            arr_vals[i] = arr_vals[i+1];
                        end
                        arr_count--;
                        r.idx = IDX_W'(at);
                    end
                end
            end
            default: begin
            end
        endcase
        r.cnt = CNT_W'(arr_count);
        return r;
    endfunction

    // Keys lean on live entries and sign corners so that matches and duplicates occur.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && arr_count > 0) begin
            return arr_vals[$urandom_range(0, arr_count - 1)];
        end
        if (sel == 5) begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Positions are mostly legal; the rest sweep the whole 4-bit field.
    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 99) < 85) begin
            return POS_W'($urandom_range(1, arr_count + 1));
        end
        return POS_W'($urandom_range(0, 15));
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Sends one command word and records its predicted result on acceptance.
    // Start is left high so that a following word can go out without a bubble.
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input logic [POS_W-1:0] p);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 17);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= f;
        i_key  <= k;
        i_pos  <= p;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_results.push_back(apply_array_op(f, k, p));
    endtask

    // Drops start and waits until every predicted result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Checks each strobed result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word, status", o_status, 0);
            end else begin
                head_result = pending_results.pop_front();
                if (o_found_index !== head_result.idx) begin
                    flag_mismatch("found_index", o_found_index, $signed(head_result.idx));
                end
                if (o_new_count !== head_result.cnt) begin
                    flag_mismatch("new_count", o_new_count, head_result.cnt);
                end
                if (o_status !== head_result.stat) begin
                    flag_mismatch("status", o_status, head_result.stat);
                end
            end
        end
    end

    // Corner cases: empty array, bad positions, sign extremes, full array.
    task automatic test_directed();
        send_word(FUNC_SEARCH, 32'h0000_0000, 4'd0);
        send_word(FUNC_DELETE, 32'h0000_0000, 4'd0);
        send_word(FUNC_INSERT, 32'h1234_5678, 4'd0);
        send_word(FUNC_INSERT, 32'h1234_5678, 4'd2);
        send_word(FUNC_INSERT, 32'h8000_0000, 4'd1);
        send_word(FUNC_INSERT, 32'h7FFF_FFFF, 4'd2);
        send_word(FUNC_INSERT, 32'hFFFF_FFFF, 4'd1);
        send_word(FUNC_INSERT, 32'h0000_0000, 4'd2);
        send_word(FUNC_SEARCH, 32'h7FFF_FFFF, 4'd15);
        send_word(FUNC_SEARCH, 32'h0001_E240, 4'd0);
        send_word(FUNC_NOP, 32'hA5A5_A5A5, 4'd15);
        send_word(FUNC_INSERT, 32'h8000_0000, 4'd5);
        send_word(FUNC_DELETE, 32'h8000_0000, 4'd0);
        send_word(FUNC_INSERT, 32'h5555_5555, 4'd6);
        // Fill the rest by appending, then try to insert into the full array.
        while (arr_count < CAPACITY) begin
            send_word(FUNC_INSERT, 32'h0F0F_0000 + arr_count, POS_W'(arr_count + 1));
        end
        send_word(FUNC_INSERT, 32'hDEAD_BEEF, 4'd15);
        send_word(FUNC_INSERT, 32'hDEAD_BEEF, 4'd1);
        send_word(FUNC_SEARCH, arr_vals[CAPACITY-1], 4'd0);
        send_word(FUNC_DELETE, arr_vals[0], 4'd0);
        send_word(FUNC_DELETE, arr_vals[arr_count-1], 4'd0);
        send_word(FUNC_DELETE, 32'hDEAD_BEEF, 4'd0);
    endtask

    // Rounds: fill to capacity, probe, delete every live entry, probe again.
    task automatic test_fill_drain(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            while (arr_count < CAPACITY) begin
                send_word(FUNC_INSERT, pick_key(), POS_W'($urandom_range(1, arr_count + 1)));
            end
            send_word(FUNC_INSERT, $urandom, pick_pos());
            send_word(FUNC_SEARCH, pick_key(), pick_pos());
            send_word(FUNC_SEARCH, $urandom, pick_pos());
            while (arr_count > 0) begin
                send_word(FUNC_DELETE, arr_vals[$urandom_range(0, arr_count - 1)],
                          pick_pos());
            end
            send_word(FUNC_DELETE, pick_key(), pick_pos());
        end
    endtask

    // Mixed random traffic; calm and bursty stretches of 100 words mix at random.
    task automatic test_random_traffic(input int n_words);
        int sel;
        logic [FUNC_W-1:0] f;
        for (int n = 0; n < n_words; n++) begin
            if (n % 100 == 0) begin
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            end
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                f = FUNC_INSERT;
            end else if (sel < 65) begin
                f = FUNC_SEARCH;
            end else if (sel < 95) begin
                f = FUNC_DELETE;
            end else begin
                f = FUNC_NOP;
            end
            send_word(f, pick_key(), pick_pos());
        end
    endtask

    // The sender holds off until every outstanding result has been seen.
    task automatic test_drain_pause();
        test_random_traffic(12);
        wait_for_drain();
        test_random_traffic(12);
    endtask

    // Words go out back to back with no sender idling at all.
    task automatic test_back_to_back(input int n_words);
        no_gaps = 1'b1;
        test_random_traffic(n_words);
    endtask

    initial begin
        errors    = 0;
        arr_count = 0;
        no_gaps   = 1'b0;
        gap_pct   = 30;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_drain(20);
        test_drain_pause();
        test_random_traffic(680);
        test_back_to_back(150);
        wait_for_drain();
        repeat (CAPACITY + 4) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
